// ----- src/s8b_pkg.sv -----
// ----------------------------------------------------------------------------
// s8b_pkg: shared types and constants of the Simple-8b word decoder
// Holds the selector tables, the queue entry layout and the element finish
// function that maps a raw item to an output value.
// ----------------------------------------------------------------------------
package s8b_pkg;

  localparam int VALUE_LANES  = 4;
  localparam int PAYLOAD_BITS = 60;
  localparam int VALUE_BITS   = 61;
  localparam int QUEUE_DEPTH  = 2;

  // Selectors that repeat the whole payload.
  localparam logic [3:0] SEL_RPT240 = 4'd0;
  localparam logic [3:0] SEL_RPT120 = 4'd1;

  // Element size codes.
  localparam logic [1:0] ESZ_8  = 2'd0;
  localparam logic [1:0] ESZ_16 = 2'd1;
  localparam logic [1:0] ESZ_32 = 2'd2;
  localparam logic [1:0] ESZ_64 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIGNED   = 2'd0;
  localparam logic [1:0] REG_ESIZE    = 2'd1;
  localparam logic [1:0] REG_EXPECTED = 2'd2;

  localparam logic [5:0] ITEM_BITS [16] = '{
    6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6,
    6'd7, 6'd8, 6'd10, 6'd12, 6'd15, 6'd20, 6'd30, 6'd60
  };

  localparam logic [7:0] GROUP_LEN [16] = '{
    8'd240, 8'd120, 8'd60, 8'd30, 8'd20, 8'd15, 8'd12, 8'd10,
    8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1
  };

  // One classified word, as it waits between front and back.
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]         payload;
    logic [7:0]                      group_len;
    logic [5:0]                      item_w;
    logic [7:0]                      step;
    logic [VALUE_LANES-1:0][5:0]     lane_sh;
    logic                            first;
  } s8b_entry_t;

  // Cut an item to the element width, then zigzag-decode and sign-extend
  // it when signed mode is on.
  function automatic logic [VALUE_BITS-1:0] finish_value(
    input logic [PAYLOAD_BITS-1:0] item,
    input logic                    sgn,
    input logic [1:0]              esize
  );
    logic [63:0] emask;
    logic [63:0] u;
    logic [63:0] z;
    logic        msb;
    case (esize)
      ESZ_8: begin
        emask = 64'h0000_0000_0000_00FF;
      end
      ESZ_16: begin
        emask = 64'h0000_0000_0000_FFFF;
      end
      ESZ_32: begin
        emask = 64'h0000_0000_FFFF_FFFF;
      end
      default: begin
        emask = '1;
      end
    endcase
    u = {4'b0, item} & emask;
    z = ((u >> 1) ^ {64{u[0]}}) & emask;
    case (esize)
      ESZ_8: begin
        msb = z[7];
      end
      ESZ_16: begin
        msb = z[15];
      end
      ESZ_32: begin
        msb = z[31];
      end
      default: begin
        msb = 1'b0;
      end
    endcase
    if (sgn) begin
      u = msb ? (z | ~emask) : z;
    end
    return u[VALUE_BITS-1:0];
  endfunction

endpackage

// ----- src/s8b_if.sv -----
// ----------------------------------------------------------------------------
// s8b_in_if / s8b_out_if: request channels of the Simple-8b word decoder
// Valid/ready channels carrying one packed word in and one beat of values out.
// ----------------------------------------------------------------------------
interface s8b_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_word;
  logic        first_word;

  modport source (output valid, output packed_word, output first_word, input ready);
  modport sink   (input valid, input packed_word, input first_word, output ready);
endinterface

interface s8b_out_if;
  logic               valid;
  logic               ready;
  logic signed [60:0] value_lane0;
  logic signed [60:0] value_lane1;
  logic signed [60:0] value_lane2;
  logic signed [60:0] value_lane3;
  logic [2:0]         lanes_used;
  logic               last_of_word;
  logic               count_overrun;

  modport source (output valid, output value_lane0, output value_lane1, output value_lane2,
                  output value_lane3, output lanes_used, output last_of_word,
                  output count_overrun, input ready);
  modport sink   (input valid, input value_lane0, input value_lane1, input value_lane2,
                  input value_lane3, input lanes_used, input last_of_word,
                  input count_overrun, output ready);
endinterface

// ----- src/simple8b_word_decoder.sv -----
// ----------------------------------------------------------------------------
// simple8b_word_decoder: Simple-8b packed word decoder
// Front classifier, two-entry word queue and beat sequencer with a
// registered output stage; configuration registers live here.
// ----------------------------------------------------------------------------
// A word with group length G leaves as ceil(G / L) beats, L being LANES held
// to 1..4, one beat per clock while the output side takes them; the beat
// sequencer adds a load step per word to take it from the queue. A selector 0
// word (240 values) thus takes 60 beats at four lanes. A word dropped because
// the expected count is already reached is popped and yields no beats.
// The queue holds two words, so the input keeps accepting while a word drains.
module simple8b_word_decoder
  import s8b_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  s8b_in_if.sink      in_ch,
  s8b_out_if.source   out_ch
);

  localparam int EFF_LANES = (LANES < 1) ? 1 : ((LANES > VALUE_LANES) ? VALUE_LANES : LANES);

  logic        signed_r;
  logic [1:0]  esize_r;
  logic [31:0] expected_r;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  s8b_entry_t  q_wdata;
  s8b_entry_t  q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r   <= 1'b0;
      esize_r    <= ESZ_64;
      expected_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGNED: begin
          signed_r <= cfg_wdata[0];
        end
        REG_ESIZE: begin
          esize_r <= cfg_wdata[1:0];
        end
        REG_EXPECTED: begin
          expected_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  s8b_front #(
    .EFF_LANES (EFF_LANES)
  ) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  s8b_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  s8b_back #(
    .EFF_LANES (EFF_LANES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .signed_values     (signed_r),
    .element_size_code (esize_r),
    .expected_count    (expected_r),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_ch            (out_ch)
  );

endmodule

// ----- src/s8b_front.sv -----
// ----------------------------------------------------------------------------
// s8b_front: word classifier
// Accepts packed words and turns the selector into the group length, item
// width, per-beat shift and per-lane extraction offsets for the back end.
// ----------------------------------------------------------------------------
module s8b_front
  import s8b_pkg::*;
#(
  parameter int EFF_LANES = 4
) (
  s8b_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output s8b_entry_t q_wdata
);

  logic [3:0] sel;
  logic       rpt;
  logic [5:0] w;
  int         sh;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    sel = in_ch.packed_word[63:60];
    rpt = (sel <= SEL_RPT120);
    // Repeat words carry one 60-bit item that never moves.
    w   = rpt ? 6'(PAYLOAD_BITS) : ITEM_BITS[sel];
    q_wdata.payload   = in_ch.packed_word[PAYLOAD_BITS-1:0];
    q_wdata.group_len = GROUP_LEN[sel];
    q_wdata.item_w    = w;
    q_wdata.step      = rpt ? 8'd0 : 8'(EFF_LANES * int'(w));
    q_wdata.first     = in_ch.first_word;
    for (int k = 0; k < VALUE_LANES; k++) begin
      sh = PAYLOAD_BITS - (k + 1) * int'(w);
      q_wdata.lane_sh[k] = (rpt || sh < 0) ? 6'd0 : 6'(sh);
    end
  end

endmodule

// ----- src/s8b_queue.sv -----
// ----------------------------------------------------------------------------
// s8b_queue: short word queue
// Holds classified words between the front and the back so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module s8b_queue
  import s8b_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  s8b_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output s8b_entry_t rdata,
  output logic       empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  s8b_entry_t         ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        ent_r[wr_ptr_r] <= wdata;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ----- src/s8b_back.sv -----
// ----------------------------------------------------------------------------
// s8b_back: beat sequencer
// Takes one classified word at a time, keeps the running value count and
// emits the word's values a beat at a time into a registered output stage.
// ----------------------------------------------------------------------------
module s8b_back
  import s8b_pkg::*;
#(
  parameter int EFF_LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        signed_values,
  input  logic [1:0]  element_size_code,
  input  logic [31:0] expected_count,
  input  logic        q_empty,
  input  s8b_entry_t  q_rdata,
  output logic        q_pop,
  s8b_out_if.source   out_ch
);

  logic                          active_r;
  logic [PAYLOAD_BITS-1:0]       sr_r;
  logic [7:0]                    gl_r;
  logic [5:0]                    w_r;
  logic [7:0]                    step_r;
  logic [VALUE_LANES-1:0][5:0]   lane_sh_r;
  logic [7:0]                    done_r;
  logic [32:0]                   total_r;

  logic                          out_valid_r;
  logic [VALUE_BITS-1:0]         val_r [VALUE_LANES];
  logic [2:0]                    used_r;
  logic                          last_r;
  logic                          ovr_r;

  logic [32:0]                   total_eff;
  logic                          start;
  logic                          fire;
  logic [7:0]                    rem;
  logic [2:0]                    used;
  logic [7:0]                    done_nxt;
  logic [32:0]                   total_nxt;
  logic                          last;
  logic [PAYLOAD_BITS-1:0]       wmask;
  logic [VALUE_BITS-1:0]         val_nxt [VALUE_LANES];

  always_comb begin
    q_pop     = !active_r && !q_empty;
    total_eff = q_rdata.first ? '0 : total_r;
    // A word that arrives once the count is reached is dropped.
    start     = q_pop && (total_eff < {1'b0, expected_count});
    fire      = active_r && (!out_valid_r || out_ch.ready);
    rem       = gl_r - done_r;
    used      = (rem < 8'(EFF_LANES)) ? rem[2:0] : 3'(EFF_LANES);
    done_nxt  = done_r + 8'(used);
    total_nxt = total_r + 33'(used);
    last      = (done_nxt >= gl_r);
    wmask     = {PAYLOAD_BITS{1'b1}} >> (6'(PAYLOAD_BITS) - w_r);
    for (int k = 0; k < VALUE_LANES; k++) begin
      if (k < EFF_LANES && (int'(done_r) + k) < int'(gl_r)) begin
        val_nxt[k] = finish_value((sr_r >> lane_sh_r[k]) & wmask, signed_values,
                                  element_size_code);
      end else begin
        val_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (q_pop) begin
        total_r   <= total_eff;
        active_r  <= start;
        sr_r      <= q_rdata.payload;
        gl_r      <= q_rdata.group_len;
        w_r       <= q_rdata.item_w;
        step_r    <= q_rdata.step;
        lane_sh_r <= q_rdata.lane_sh;
        done_r    <= '0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        val_r       <= val_nxt;
        used_r      <= used;
        last_r      <= last;
        ovr_r       <= (total_nxt > {1'b0, expected_count});
        sr_r        <= sr_r << step_r;
        done_r      <= done_nxt;
        total_r     <= total_nxt;
        if (last) begin
          active_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value_lane0   = $signed(val_r[0]);
  assign out_ch.value_lane1   = $signed(val_r[1]);
  assign out_ch.value_lane2   = $signed(val_r[2]);
  assign out_ch.value_lane3   = $signed(val_r[3]);
  assign out_ch.lanes_used    = used_r;
  assign out_ch.last_of_word  = last_r;
  assign out_ch.count_overrun = ovr_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !active_r)
    else $error("word taken from the queue while a word is in progress");

  a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (used != 3'd0) && (int'(used) <= EFF_LANES))
    else $error("beat with an out-of-range lane count");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (done_r < gl_r))
    else $error("active word has no values left");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last) |=> !active_r && out_valid_r && last_r)
    else $error("final beat did not close the word");

endmodule

// ----- tb/s8b_decode_checker.sv -----
// ----------------------------------------------------------------------------
// s8b_decode_checker: prediction and comparison for the Simple-8b word decoder
// Watches the configuration port and both request channels. For every accepted
// word it unpacks the expected beats, then compares each accepted beat with the
// oldest one still due.
// ----------------------------------------------------------------------------
module s8b_decode_checker
  import s8b_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  s8b_in_if           in_ch,
  s8b_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_beats
);

  localparam int LANE_CNT = (LANES < 1) ? 1 : ((LANES > VALUE_LANES) ? VALUE_LANES : LANES);

  typedef struct packed {
    logic [VALUE_LANES-1:0][VALUE_BITS-1:0] lane;
    logic [2:0]                             used;
    logic                                   last;
    logic                                   over;
  } beat_t;

  beat_t       due_beats[$];
  logic        sgn_r;
  logic [1:0]  esz_r;
  logic [31:0] count_r;
  logic [32:0] block_sum;
  int unsigned errors;

  // Cut a raw item to the element width and apply zigzag decoding when enabled.
  function automatic logic [VALUE_BITS-1:0] lane_value(input logic [PAYLOAD_BITS-1:0] raw);
    logic [63:0] keep;
    logic [63:0] v;
    int unsigned ew;
    case (esz_r)
      ESZ_8: begin
        ew = 8;
      end
      ESZ_16: begin
        ew = 16;
      end
      ESZ_32: begin
        ew = 32;
      end
      default: begin
        ew = 64;
      end
    endcase
    keep = (ew == 64) ? '1 : ((64'd1 << ew) - 64'd1);
    v = {4'b0, raw} & keep;
    if (sgn_r) begin
      v = ((v >> 1) ^ {64{v[0]}}) & keep;
      if (ew < 64 && v[ew-1]) begin
        v = v | ~keep;
      end
    end
    return v[VALUE_BITS-1:0];
  endfunction

  // Expand one accepted word into the beats it should produce.
  function automatic void unpack_word(input logic [63:0] word, input logic first);
    logic [3:0]              sel;
    logic [63:0]             pl;
    logic [63:0]             imask;
    int unsigned             gl;
    int unsigned             iw;
    int unsigned             done;
    int unsigned             k;
    beat_t                   b;
    sel = word[63:60];
    pl  = {4'b0, word[59:0]};
    gl  = GROUP_LEN[sel];
    iw  = ITEM_BITS[sel];
    if (first) begin
      block_sum = '0;
    end
    // Once the block has reached its count, further words are swallowed.
    if (block_sum >= {1'b0, count_r}) begin
      return;
    end
    if (sel > SEL_RPT120) begin
      pl = pl >> (PAYLOAD_BITS % gl);
    end
    imask = (64'd1 << iw) - 64'd1;
    done = 0;
    while (done < gl) begin
      b = '0;
      for (k = 0; k < VALUE_LANES; k++) begin
        if (k < LANE_CNT && done < gl) begin
          if (sel <= SEL_RPT120) begin
            b.lane[k] = lane_value(pl[59:0]);
          end else begin
            b.lane[k] = lane_value(60'((pl >> ((gl - 1 - done) * iw)) & imask));
          end
          done++;
          b.used++;
        end
      end
      block_sum = block_sum + b.used;
      b.last = (done >= gl);
      b.over = (block_sum > {1'b0, count_r});
      due_beats.push_back(b);
    end
  endfunction

  task automatic check_field(input string name, input logic [VALUE_BITS-1:0] want,
                             input logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    beat_t got;
    beat_t want;
    int    k;
    if (!rst_n) begin
      due_beats.delete();
      sgn_r     = 1'b0;
      esz_r     = ESZ_64;
      count_r   = '0;
      block_sum = '0;
      errors    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.lane[0] = out_ch.value_lane0;
        got.lane[1] = out_ch.value_lane1;
        got.lane[2] = out_ch.value_lane2;
        got.lane[3] = out_ch.value_lane3;
        got.used    = out_ch.lanes_used;
        got.last    = out_ch.last_of_word;
        got.over    = out_ch.count_overrun;
        if (due_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual lanes_used=%0d lane0=%h",
                   $time, got.used, got.lane[0]);
        end else begin
          want = due_beats.pop_front();
          for (k = 0; k < VALUE_LANES; k++) begin
            check_field($sformatf("value_lane%0d", k), want.lane[k], got.lane[k]);
          end
          check_field("lanes_used", 61'(want.used), 61'(got.used));
          check_field("last_of_word", 61'(want.last), 61'(got.last));
          check_field("count_overrun", 61'(want.over), 61'(got.over));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIGNED: begin
            sgn_r = cfg_wdata[0];
          end
          REG_ESIZE: begin
            esz_r = cfg_wdata[1:0];
          end
          REG_EXPECTED: begin
            count_r = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        unpack_word(in_ch.packed_word, in_ch.first_word);
      end
    end
    fail_count    <= errors;
    pending_beats <= due_beats.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: top level test of the Simple-8b word decoder
// Drives a directed set of words over all selectors, element sizes and count
// corner cases, then random blocks of words under random register settings,
// with bursty requests in and a stalling receiver out. The checker beside the
// block predicts every beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb
  import s8b_pkg::*;
();

  localparam int LANES_TB      = 4;
  localparam int RANDOM_WORDS  = 360;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int unsigned fail_count;
  int unsigned pending_beats;
  int unsigned cycles = 0;

  // Sender bookkeeping; the running total only decides which words count.
  int unsigned burst_left = 0;
  int unsigned gap;
  int unsigned live_words;
  logic [32:0] run_total = '0;
  logic [31:0] cnt_now = '0;

  // Random phase controls.
  logic        sgn;
  logic [1:0]  esz;
  logic [31:0] cnt;
  logic [32:0] room;
  logic [3:0]  sel;
  int unsigned style;
  int unsigned nwords;
  int unsigned cap;
  int unsigned s;

  // Receiver controls.
  int unsigned rx_mode;
  int unsigned rx_left = 0;

  s8b_in_if  in_ch ();
  s8b_out_if out_ch ();

  simple8b_word_decoder #(.LANES(LANES_TB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  s8b_decode_checker #(.LANES(LANES_TB)) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: switches between full speed, light, heavy and periodic stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 300);
      end
      rx_left--;
      case (rx_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ch.ready <= ((rx_left % 7) > 2);
        end
      endcase
    end
  end

  // Random word of the given selector; items lean toward their extremes.
  function automatic logic [63:0] make_word(input logic [3:0] sel_in);
    logic [63:0] pl;
    logic [63:0] fld;
    logic [63:0] fmask;
    int unsigned gl;
    int unsigned iw;
    int unsigned pad;
    int unsigned g;
    pl = {$urandom, $urandom};
    gl = GROUP_LEN[sel_in];
    iw = ITEM_BITS[sel_in];
    if (sel_in <= SEL_RPT120) begin
      case ($urandom_range(0, 3))
        0: begin
          pl = '1;
        end
        1: begin
          pl = '0;
        end
        default: begin
        end
      endcase
    end else begin
      pad   = PAYLOAD_BITS % gl;
      fmask = (64'd1 << iw) - 64'd1;
      for (g = 0; g < gl; g++) begin
        case ($urandom_range(0, 4))
          0: begin
            fld = fmask;
          end
          1: begin
            fld = '0;
          end
          2: begin
            fld = 64'd1 << (iw - 1);
          end
          3: begin
            fld = 64'd1;
          end
          default: begin
            fld = {$urandom, $urandom} & fmask;
          end
        endcase
        pl = (pl & ~(fmask << (pad + g * iw))) | (fld << (pad + g * iw));
      end
    end
    return {sel_in, pl[59:0]};
  endfunction

  // Selector whose group still fits in the remaining count.
  function automatic logic [3:0] pick_sel(input logic [32:0] left);
    logic [3:0] p;
    p = 4'($urandom_range(0, 15));
    while (GROUP_LEN[p] > left) begin
      p = p + 4'd1;
    end
    return p;
  endfunction

  task automatic send_word(input logic [63:0] word, input logic first);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.packed_word <= word;
    in_ch.first_word  <= first;
    do @(posedge clk); while (!in_ch.ready);
    if (first) begin
      run_total = '0;
    end
    if (run_total < {1'b0, cnt_now}) begin
      run_total = run_total + GROUP_LEN[word[63:60]];
      live_words++;
    end
  endtask

  // Stop sending and wait until every predicted beat has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic sv, input logic [1:0] ev, input logic [31:0] cv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIGNED;
    cfg_wdata <= {31'b0, sv};
    @(posedge clk);
    cfg_index <= REG_ESIZE;
    cfg_wdata <= {30'b0, ev};
    @(posedge clk);
    cfg_index <= REG_EXPECTED;
    cfg_wdata <= cv;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cnt_now = cv;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SIGNED;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.packed_word = '0;
    in_ch.first_word  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every selector at full element width, unsigned, with no count limit.
    load_regs(1'b0, ESZ_64, 32'hFFFF_FFFF);
    send_word({SEL_RPT240, 60'hFFF_FFFF_FFFF_FFFF}, 1'b1);
    send_word({SEL_RPT120, 60'h0}, 1'b0);
    for (s = 2; s < 16; s++) begin
      send_word(make_word(4'(s)), 1'b0);
    end
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'hF000_0000_0000_0000, 1'b0);

    // A group that runs past the count, a word after the count is reached,
    // and a fresh block with one lane left empty.
    drain_results();
    load_regs(1'b1, ESZ_8, 32'd10);
    send_word({4'd2, 60'h555_5555_5555_5555}, 1'b1);
    send_word(make_word(4'd15), 1'b0);
    send_word({4'd13, 60'h80000_7FFFF_FFFFF}, 1'b1);

    // A count of zero swallows even the first word.
    drain_results();
    load_regs(1'b1, ESZ_16, 32'd0);
    send_word(make_word(4'd12), 1'b1);

    drain_results();
    load_regs(1'b1, ESZ_32, 32'hFFFF_FFFF);
    send_word({4'd15, 60'h000_0000_FFFF_FFFF}, 1'b1);
    send_word({4'd14, 30'h3FFF_FFFF, 30'h0}, 1'b0);
    send_word({4'd15, 60'hFFF_FFFF_FFFF_FFFF}, 1'b0);

    drain_results();
    load_regs(1'b0, ESZ_8, 32'd1);
    send_word({4'd9, 60'hFFF_FFFF_FFFF_FFFF}, 1'b1);

    drain_results();
    load_regs(1'b1, ESZ_64, 32'd100);
    send_word({4'd15, 60'hFFF_FFFF_FFFF_FFFF}, 1'b1);
    send_word({4'd11, 60'hAAA_AAAA_AAAA_AAAA}, 1'b0);

    // Random phases: mostly blocks that fill the count exactly, with short
    // broken blocks, blocks that overshoot and loose noise words mixed in.
    live_words = 0;
    while (live_words < RANDOM_WORDS) begin
      sgn = 1'($urandom_range(0, 1));
      esz = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 11))
        0: begin
          cnt = '0;
        end
        1: begin
          cnt = '1;
        end
        2: begin
          cnt = 32'd1;
        end
        default: begin
          cnt = $urandom_range(2, 600);
        end
      endcase
      drain_results();
      load_regs(sgn, esz, cnt);
      repeat ($urandom_range(1, 4)) begin
        style = $urandom_range(0, 9);
        if (style == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_word(make_word(4'($urandom_range(0, 15))), 1'($urandom_range(0, 1)));
          end
        end else begin
          room   = {1'b0, cnt};
          nwords = 0;
          cap    = (style == 1) ? $urandom_range(1, 3) : 20;
          do begin
            if (style == 3 || room == 0) begin
              sel = 4'($urandom_range(0, 15));
            end else begin
              sel = pick_sel(room);
            end
            send_word(make_word(sel), nwords == 0);
            room = (room > GROUP_LEN[sel]) ? (room - GROUP_LEN[sel]) : '0;
            nwords++;
          end while (room != 0 && nwords < cap);
          if (style == 2) begin
            repeat ($urandom_range(1, 3)) begin
              send_word(make_word(4'($urandom_range(0, 15))), 1'b0);
            end
          end
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
